### rtl/core/lgu_pkg.sv
// ----------------------------------------------------------------------------
// lgu_pkg
// Shared widths, constants and stage types of the Lorentz gamma unit.
// ----------------------------------------------------------------------------
package lgu_pkg;

   localparam int BETA_W  = 32;
   localparam int CLAMP_W = 30;
   localparam int MAG_W   = 30;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int DEN_W   = SQ_W + 1;
   localparam int ROOT_W  = 40;
   localparam int REM_W   = ROOT_W + 2;
   localparam int GAMMA_W = 40;

   localparam int NUM_CELLS  = 80;
   localparam int ROOT_FIRST = 2;

   localparam logic [CLAMP_W-1:0] CLAMP_RESET = 30'd1073634450;
   localparam logic signed [BETA_W-1:0] NEG_ONE_Q30 = -32'sd1073741824;
   localparam logic [DEN_W-1:0] ONE_Q60 = 61'h1000_0000_0000_0000;
   localparam logic [DEN_W-1:0] REM_START = 61'h0000_0000_4000_0000;
   localparam logic [GAMMA_W-1:0] GAMMA_MAX = '1;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              invalid;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  part;
      logic [1:0]        qbits;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
   } lgu_stage_type;

   typedef struct packed {
      logic               valid;
      logic [GAMMA_W-1:0] gamma;
      logic               invalid;
      logic               last;
   } lgu_result_type;

endpackage

### rtl/core/lgu_prep.sv
// ----------------------------------------------------------------------------
// lgu_prep
// Clamp beta, square its magnitude and form the denominator 2^60 - beta^2.
// ----------------------------------------------------------------------------
module lgu_prep
   import lgu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [CLAMP_W-1:0]       clamp_limit,
   input  logic                     in_valid,
   input  logic signed [BETA_W-1:0] in_beta,
   input  logic                     in_last,
   output lgu_stage_type            stage_dn
);

   logic signed [BETA_W-1:0] limit;
   logic signed [BETA_W-1:0] beta_cl;
   logic [BETA_W-1:0]        beta_abs;

   logic             v1_ff, v1_in;
   logic             last1_ff, last1_in;
   logic             inv1_ff, inv1_in;
   logic [MAG_W-1:0] mag1_ff, mag1_in;

   logic             v2_ff;
   logic             last2_ff;
   logic             inv2_ff;
   logic [SQ_W-1:0]  sq2_ff, sq2_in;

   lgu_stage_type    stage_ff, stage_in;

   always_comb begin
      limit    = $signed({{(BETA_W-CLAMP_W){1'b0}}, clamp_limit});
      beta_cl  = (in_beta > limit) ? limit : in_beta;
      inv1_in  = (beta_cl <= NEG_ONE_Q30);
      beta_abs = beta_cl[BETA_W-1] ? BETA_W'(-beta_cl) : BETA_W'(beta_cl);
      mag1_in  = inv1_in ? '0 : beta_abs[MAG_W-1:0];
      v1_in    = in_valid;
      last1_in = in_last;
   end

   assign sq2_in = mag1_ff * mag1_ff;

   always_comb begin
      stage_in         = '0;
      stage_in.valid   = v2_ff;
      stage_in.last    = last2_ff;
      stage_in.invalid = inv2_ff;
      stage_in.den     = ONE_Q60 - {1'b0, sq2_ff};
      stage_in.part    = REM_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff    <= v1_in;
         last1_ff <= last1_in;
         inv1_ff  <= inv1_in;
         mag1_ff  <= mag1_in;
         v2_ff    <= v1_ff;
         last2_ff <= last1_ff;
         inv2_ff  <= inv1_ff;
         sq2_ff   <= sq2_in;
         stage_ff <= stage_in;
      end
   end

   assign stage_dn = stage_ff;

endmodule

### rtl/core/lgu_cell.sv
// ----------------------------------------------------------------------------
// lgu_cell
// One cell of the chain: one restoring quotient bit of 2^110/d and, when
// enabled, one digit pair of the integer square root of that quotient.
// ----------------------------------------------------------------------------
module lgu_cell
   import lgu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          root_on,
   input  lgu_stage_type stage_up,
   output lgu_stage_type stage_dn
);

   logic [DEN_W:0]    part_sh;
   logic              q_bit;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              r_bit;
   lgu_stage_type     stage_ff, stage_in;

   always_comb begin
      part_sh = {stage_up.part, 1'b0};
      q_bit   = (part_sh >= {1'b0, stage_up.den});
      rem_sh  = {stage_up.rem, stage_up.qbits};
      trial   = {stage_up.root, 2'b01};
      r_bit   = (rem_sh >= {2'b00, trial});

      stage_in       = stage_up;
      stage_in.part  = q_bit ? DEN_W'(part_sh - {1'b0, stage_up.den}) : part_sh[DEN_W-1:0];
      stage_in.qbits = {stage_up.qbits[0], q_bit};
      if (root_on) begin
         stage_in.rem  = r_bit ? REM_W'(rem_sh - {2'b00, trial}) : rem_sh[REM_W-1:0];
         stage_in.root = {stage_up.root[ROOT_W-2:0], r_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_dn = stage_ff;

endmodule

### rtl/core/lgu_tail.sv
// ----------------------------------------------------------------------------
// lgu_tail
// Last root digit, round to nearest, saturate and select the invalid code.
// ----------------------------------------------------------------------------
module lgu_tail
   import lgu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  lgu_stage_type  stage_up,
   output lgu_result_type res_dn
);

   logic [REM_W+1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              r_bit;
   logic [ROOT_W:0]   sum;
   lgu_result_type    res_ff, res_in;

   always_comb begin
      rem_sh = {stage_up.rem, stage_up.qbits};
      trial  = {stage_up.root, 2'b01};
      r_bit  = (rem_sh >= {2'b00, trial});
      // round: (2*root + bit + 1) >> 1 == root + bit
      sum    = {1'b0, stage_up.root} + {{ROOT_W{1'b0}}, r_bit};

      res_in.valid   = stage_up.valid;
      res_in.last    = stage_up.last;
      res_in.invalid = stage_up.invalid;
      if (stage_up.invalid || sum[ROOT_W]) begin
         res_in.gamma = GAMMA_MAX;
      end else begin
         res_in.gamma = GAMMA_W'(sum[ROOT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_dn = res_ff;

endmodule

### rtl/core/lorentz_gamma_unit_top.sv
// ----------------------------------------------------------------------------
// lorentz_gamma_unit_top
// Lorentz factor 1/sqrt(1 - beta^2) of one clamped Q1.30 beta per beat.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while req_stall is low. Each beat passes the
// three front stages, which clamp, square and subtract, then the chain of 80
// cells, each resolving one quotient bit of 2^110/d and, every other cell, one
// root digit pair, then one tail stage that rounds, and the output register.
// A result waiting at a stalled output does not block input: a one-beat skid
// register catches the next result and req_stall rises only once it is full.
// Beta at or below -1.0 returns gamma all ones with invalid set. The clamp
// register resets to just below one and may be written only while idle.
// ----------------------------------------------------------------------------
module lorentz_gamma_unit_top
   import lgu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [BETA_W-1:0] req_beta,
   input  logic                     req_last_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [GAMMA_W-1:0]       rsp_gamma,
   output logic                     rsp_invalid,
   output logic                     rsp_last_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CLAMP_W-1:0]       csr_data
);

   logic [CLAMP_W-1:0] clamp_ff, clamp_in;
   logic               en;
   logic               take;

   lgu_stage_type      chain [NUM_CELLS+1];
   lgu_result_type     tail_res;
   lgu_result_type     rsp_ff, rsp_in;
   lgu_result_type     skid_ff, skid_in;

   assign csr_ready = 1'b1;
   assign clamp_in  = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= CLAMP_RESET;
      end else if (csr_valid && csr_ready) begin
         clamp_ff <= clamp_in;
      end
   end

   // advance the whole chain while the skid stage is empty
   assign en        = !skid_ff.valid;
   assign req_stall = skid_ff.valid;
   assign take      = rsp_ff.valid && !rsp_stall;

   lgu_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .clamp_limit (clamp_ff),
      .in_valid    (req_valid),
      .in_beta     (req_beta),
      .in_last     (req_last_in),
      .stage_dn    (chain[0])
   );

   for (genvar s = 0; s < NUM_CELLS; s++) begin : g_cell
      localparam logic ROOT_ON = (s >= ROOT_FIRST) && ((s % 2) == 0);
      lgu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .root_on  (ROOT_ON),
         .stage_up (chain[s]),
         .stage_dn (chain[s+1])
      );
   end

   lgu_tail u_tail (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .stage_up (chain[NUM_CELLS]),
      .res_dn   (tail_res)
   );

   always_comb begin
      rsp_in  = rsp_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (take) begin
            rsp_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (tail_res.valid) begin
         if (!rsp_ff.valid || take) begin
            rsp_in = tail_res;
         end else begin
            skid_in = tail_res;
         end
      end else if (take) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         rsp_ff  <= rsp_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_valid    = rsp_ff.valid;
   assign rsp_gamma    = rsp_ff.gamma;
   assign rsp_invalid  = rsp_ff.invalid;
   assign rsp_last_out = rsp_ff.last;

   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_ff.valid |-> rsp_ff.valid)
      else $error("skid holds a beat while the output register is empty");

   a_skid_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_ff.valid) |-> $past(rsp_stall) && $past(rsp_ff.valid))
      else $error("skid filled without a stalled output beat");

   a_invalid_max : assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.invalid |-> rsp_ff.gamma == GAMMA_MAX)
      else $error("invalid beat without saturated gamma");

endmodule

### verif/lgu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgu_checker
// Scoreboard for the Lorentz gamma unit: watches the request, response and
// clamp register channels, predicts each gamma beat with exact integer
// arithmetic and compares the responses in order.
// ----------------------------------------------------------------------------
module lgu_checker
   import lgu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [BETA_W-1:0] req_beta,
   input  logic                     req_last_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [GAMMA_W-1:0]       rsp_gamma,
   input  logic                     rsp_invalid,
   input  logic                     rsp_last_out,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CLAMP_W-1:0]       csr_data,
   output int                       fail_count,
   output int                       pending_count
);

   localparam logic [CLAMP_W-1:0] CLAMP_AT_RESET = 30'd1073634450;
   localparam logic [GAMMA_W-1:0] GAMMA_CEIL     = {GAMMA_W{1'b1}};

   typedef struct packed {
      logic [GAMMA_W-1:0] gamma;
      logic               invalid;
      logic               last;
   } gamma_beat_type;

   gamma_beat_type     gamma_due_q[$];
   logic [CLAMP_W-1:0] beta_ceiling;

   function automatic logic [40:0] floor_sqrt(input logic [111:0] x);
      logic [40:0] root;
      logic [83:0] trial;
      int          i;
      root = '0;
      for (i = 40; i >= 0; i--) begin
         trial = {43'd0, root | (41'd1 << i)};
         if ({28'd0, trial * trial} <= x)
            root = trial[40:0];
      end
      return root;
   endfunction

   function automatic gamma_beat_type lorentz_gamma(input logic signed [BETA_W-1:0] beta,
                                                    input logic last);
      gamma_beat_type         res;
      logic signed [BETA_W:0] b;
      logic [29:0]            mag;
      logic [60:0]            den;
      logic [111:0]           quot;
      logic [40:0]            root;
      logic [41:0]            rounded;
      b = {beta[BETA_W-1], beta};
      if (b > $signed({3'b000, beta_ceiling}))
         b = $signed({3'b000, beta_ceiling});
      res.last = last;
      if (b <= -33'sd1073741824) begin
         res.gamma   = GAMMA_CEIL;
         res.invalid = 1'b1;
      end else begin
         mag     = 30'((b < 33'sd0) ? -b : b);
         den     = (61'd1 << 60) - mag * mag;
         quot    = (112'd1 << 110) / den;
         root    = floor_sqrt(quot);
         rounded = ({1'b0, root} + 42'd1) >> 1;
         res.gamma   = (rounded > {2'b00, GAMMA_CEIL}) ? GAMMA_CEIL : rounded[GAMMA_W-1:0];
         res.invalid = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      gamma_beat_type want;
      gamma_beat_type got;
      int             errs;
      errs = 0;
      if (reset) begin
         beta_ceiling <= CLAMP_AT_RESET;
         gamma_due_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready)
            beta_ceiling <= csr_data;
         if (req_valid && !req_stall)
            gamma_due_q.push_back(lorentz_gamma(req_beta, req_last_in));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_gamma, rsp_invalid, rsp_last_out};
            if (gamma_due_q.size() == 0) begin
               $display("%0t: unexpected beat gamma=%h invalid=%b last=%b",
                        $time, got.gamma, got.invalid, got.last);
               errs++;
            end else begin
               want = gamma_due_q.pop_front();
               if (got.gamma !== want.gamma) begin
                  $display("%0t: gamma expected %h actual %h", $time, want.gamma, got.gamma);
                  errs++;
               end
               if (got.invalid !== want.invalid) begin
                  $display("%0t: invalid expected %b actual %b",
                           $time, want.invalid, got.invalid);
                  errs++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                  errs++;
               end
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= gamma_due_q.size();
      end
   end

endmodule

### verif/lorentz_gamma_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentz_gamma_unit_top_tb
// Drives directed and random beta beats through the gamma unit under several
// clamp settings, with random gaps and output stalls, and reports the verdict
// from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module lorentz_gamma_unit_top_tb;
   import lgu_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 120;
   localparam logic [CLAMP_W-1:0] CLAMP_TOP = '1;

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic signed [BETA_W-1:0] req_beta     = '0;
   logic                     req_last_in  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic [GAMMA_W-1:0]       rsp_gamma;
   logic                     rsp_invalid;
   logic                     rsp_last_out;
   logic                     csr_valid    = 1'b0;
   logic                     csr_ready;
   logic [CLAMP_W-1:0]       csr_data     = '0;

   int                 fail_count;
   int                 pending_count;
   int                 quiet_cycles = 0;
   logic               calm         = 1'b0;
   logic [CLAMP_W-1:0] clamp_now    = CLAMP_RESET;

   lorentz_gamma_unit_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_beta     (req_beta),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_gamma    (rsp_gamma),
      .rsp_invalid  (rsp_invalid),
      .rsp_last_out (rsp_last_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   lgu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_beta      (req_beta),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_gamma     (rsp_gamma),
      .rsp_invalid   (rsp_invalid),
      .rsp_last_out  (rsp_last_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic signed [BETA_W-1:0] beta, input logic last);
      req_beta    <= beta;
      req_last_in <= last;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!calm) begin
         while ($urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // hold off until every gamma beat is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clamp(input logic [CLAMP_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      clamp_now = value;
      @(posedge clock);
   endtask

   function automatic logic signed [BETA_W-1:0] random_beta();
      int unsigned            pick;
      logic signed [BETA_W-1:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         b = $urandom;
      end else if (pick < 60) begin
         b = 32'sd1073741824 - int'($urandom_range(0, 4096));
         if ($urandom_range(0, 1) == 1)
            b = -b;
      end else if (pick < 75) begin
         b = int'({2'b00, clamp_now}) + int'($urandom_range(0, 64)) - 32;
      end else begin
         b = int'($urandom_range(0, 32'h7FFF_FFFE)) - 32'sh3FFF_FFFF;
      end
      return b;
   endfunction

   task automatic random_run(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_beat(random_beta(), $urandom_range(0, 3) == 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(32'sd0, 1'b0);
      send_beat(32'sh7FFF_FFFF, 1'b1);
      send_beat(32'sh8000_0000, 1'b0);
      send_beat(-32'sd1073741824, 1'b1);
      send_beat(-32'sd1073741823, 1'b0);
      send_beat(32'sd1073741824, 1'b0);
      send_beat(int'({2'b00, clamp_now}), 1'b0);
      send_beat(int'({2'b00, clamp_now}) + 1, 1'b1);
      send_beat(int'({2'b00, clamp_now}) - 1, 1'b0);
      send_beat(-int'({2'b00, clamp_now}), 1'b0);
      send_beat(32'sd1, 1'b0);
      send_beat(-32'sd1, 1'b1);
      send_beat(32'sd536870912, 1'b0);
      send_beat(-32'sd536870912, 1'b1);
      settle();

      write_clamp(CLAMP_TOP);
      send_beat(32'sd1073741823, 1'b0);
      send_beat(32'sd1073741824, 1'b1);
      send_beat(-32'sd1073741823, 1'b0);
      random_run(300);
      settle();

      write_clamp('0);
      send_beat(32'sd12345678, 1'b1);
      send_beat(-32'sd12345678, 1'b0);
      random_run(200);
      settle();

      write_clamp(CLAMP_W'($urandom_range(1, CLAMP_TOP - 1)));
      random_run(150);
      calm <= 1'b1;
      random_run(250);
      calm <= 1'b0;
      random_run(150);
      settle();

      write_clamp(CLAMP_RESET);
      random_run(250);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
